@@ rtl/grid_sample_to_gray_level_defines.svh @@
// Assertion macros shared by the gray-level normalizer RTL.
`ifndef GRID_SAMPLE_TO_GRAY_LEVEL_DEFINES_SVH
`define GRID_SAMPLE_TO_GRAY_LEVEL_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define GS2G_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define GS2G_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gs2g_pkg.sv @@
// Constants and types of the gray-level normalizer.
`default_nettype none
package gs2g_pkg;
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 56;
    localparam int NUM_W     = 64;
    localparam int GRAY_W    = 8;
    localparam int RAW_W     = 64;
    localparam int ENC_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int MANT_W    = 53;
    localparam int EXP_W     = 13;
    localparam int WIDE_W    = MANT_W + VAL_W;
    localparam int DIV_STEPS = GRAY_W;

    localparam logic [ENC_W-1:0] ENC_INT8    = 4'd0;
    localparam logic [ENC_W-1:0] ENC_UINT8   = 4'd1;
    localparam logic [ENC_W-1:0] ENC_INT16   = 4'd2;
    localparam logic [ENC_W-1:0] ENC_UINT16  = 4'd3;
    localparam logic [ENC_W-1:0] ENC_INT32   = 4'd4;
    localparam logic [ENC_W-1:0] ENC_UINT32  = 4'd5;
    localparam logic [ENC_W-1:0] ENC_FLOAT32 = 4'd6;
    localparam logic [ENC_W-1:0] ENC_FLOAT64 = 4'd7;

    localparam logic [CFG_IDX_W-1:0] REG_ENCODING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 2'd2;

    localparam logic [ENC_W-1:0] RST_ENCODING = ENC_UINT8;
    localparam logic [VAL_W-1:0] RST_LOW      = '0;
    localparam logic [VAL_W-1:0] RST_HIGH     = 56'd16711680;

    localparam logic [VAL_W-1:0] BIAS      = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

    // Exponent offsets: bias plus mantissa bits minus fraction bits.
    localparam logic signed [EXP_W-1:0] F32_OFS = EXP_W'(127 + 23 - FRAC_BITS);
    localparam logic signed [EXP_W-1:0] F64_OFS = EXP_W'(1023 + 52 - FRAC_BITS);

    typedef struct packed {
        logic                     vld;
        logic                     last;
        logic                     bad;
        logic                     flt;
        logic [VAL_W-1:0]         vint;
        logic                     neg;
        logic                     nan;
        logic                     inf;
        logic                     zero;
        logic [MANT_W-1:0]        mant;
        logic signed [EXP_W-1:0]  shamt;
    } t_dec;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             bad;
        logic             flt;
        logic [VAL_W-1:0] vint;
        logic             neg;
        logic             nan;
        logic             inf;
        logic             zero;
        logic             big;
        logic             over;
        logic [VAL_W-1:0] mag;
    } t_shf;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             bad;
        logic [VAL_W-1:0] val;
    } t_fix;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             bad;
        logic             le;
        logic             ge;
        logic [VAL_W-1:0] diff;
        logic [VAL_W-1:0] den;
    } t_cmp;

    typedef struct packed {
        logic              vld;
        logic              last;
        logic              bad;
        logic              le;
        logic              ge;
        logic [NUM_W-1:0]  rem;
        logic [VAL_W-1:0]  den;
        logic [GRAY_W-1:0] quo;
    } t_div;
endpackage
`default_nettype wire

@@ rtl/gs2g_if.sv @@
// Handshake channel interfaces of the gray-level normalizer.
`default_nettype none
interface gs2g_sample_if;
    logic                         valid;
    logic                         ready;
    logic [gs2g_pkg::RAW_W-1:0]   raw_sample;
    logic                         last_sample;
    modport source (output valid, raw_sample, last_sample, input ready);
    modport sink (input valid, raw_sample, last_sample, output ready);
endinterface

interface gs2g_gray_if;
    logic                         valid;
    logic                         ready;
    logic [gs2g_pkg::GRAY_W-1:0]  gray_level;
    logic                         last_pixel;
    modport source (output valid, gray_level, last_pixel, input ready);
    modport sink (input valid, gray_level, last_pixel, output ready);
endinterface

interface gs2g_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gs2g_pkg::CFG_IDX_W-1:0] index;
    logic [gs2g_pkg::VAL_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/grid_sample_to_gray_level.sv @@
// Top level of the gray-level normalizer: sample decode, fixed-point map and divider pipeline.
// The sample channel takes one raw map sample per request in the encoding held by
// register 0 (integers of 8, 16 or 32 bits, float32 or float64); the gray channel
// returns one 8-bit gray level per request, with the last flag copied through.
// The config channel writes register 0 (encoding), 1 (low bound) or 2 (high bound)
// and is always ready; the user must write it only while the pipeline is empty,
// which the block itself does not enforce. From sample acceptance to gray valid,
// three stages convert the sample to 56-bit fixed point, one compares against the
// bounds, one forms the scaled numerator, eight restoring-division stages each
// produce one quotient bit, and the output register holds the result. Throughput is
// one request per cycle unless the output stalls; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds and the
// sample channel drops ready; stages behind a bubble still hold until the output
// drains. Reset empties the pipeline and restores encoding uint8, low bound 0 and
// high bound 255.0.
`default_nettype none
`include "grid_sample_to_gray_level_defines.svh"
module grid_sample_to_gray_level (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    gs2g_sample_if.sink    i_sample,
    gs2g_cfg_if.sink       i_cfg,
    gs2g_gray_if.source    o_gray
);
    import gs2g_pkg::*;

    logic [ENC_W-1:0] r_enc;
    logic [VAL_W-1:0] r_low;
    logic [VAL_W-1:0] r_high;
    logic [VAL_W-1:0] lo_b;
    logic [VAL_W-1:0] hi_b;

    logic en;
    t_dec n_dec, r_dec;
    t_shf n_shf, r_shf;
    t_fix n_fix, r_fix;
    t_cmp n_cmp, r_cmp;
    t_div r_div [0:DIV_STEPS];
    t_div n_div [0:DIV_STEPS];
    logic              r_out_vld;
    logic              r_out_last;
    logic [GRAY_W-1:0] r_out_gray;
    logic [GRAY_W-1:0] n_out_gray;

    logic [VAL_W-1:0]        xs;
    logic [EXP_W-3:0]        e_raw;
    logic [MANT_W-2:0]       m_raw;
    logic                    e_ones;
    logic [EXP_W-3:0]        e_eff;
    logic [WIDE_W-1:0]       wide;
    logic [EXP_W-1:0]        rsh;
    logic [VAL_W-1:0]        limit;
    logic [VAL_W-1:0]        mag;

    assign en             = !r_out_vld || o_gray.ready;
    assign i_sample.ready = en;
    assign i_cfg.ready    = 1'b1;
    assign lo_b           = r_low ^ BIAS;
    assign hi_b           = r_high ^ BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc  <= RST_ENCODING;
            r_low  <= RST_LOW;
            r_high <= RST_HIGH;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENCODING: r_enc  <= i_cfg.data[ENC_W-1:0];
                REG_LOW:      r_low  <= i_cfg.data;
                REG_HIGH:     r_high <= i_cfg.data;
                default:      r_enc  <= r_enc;
            endcase
        end
    end

    // Stage 1: field decode.
    always_comb begin
        n_dec       = '0;
        n_dec.vld   = i_sample.valid;
        n_dec.last  = i_sample.last_sample;
        xs          = '0;
        e_raw       = '0;
        m_raw       = '0;
        e_ones      = 1'b0;
        unique case (r_enc)
            ENC_INT8:    xs = VAL_W'($signed(i_sample.raw_sample[7:0]));
            ENC_UINT8:   xs = VAL_W'(i_sample.raw_sample[7:0]);
            ENC_INT16:   xs = VAL_W'($signed(i_sample.raw_sample[15:0]));
            ENC_UINT16:  xs = VAL_W'(i_sample.raw_sample[15:0]);
            ENC_INT32:   xs = VAL_W'($signed(i_sample.raw_sample[31:0]));
            ENC_UINT32:  xs = VAL_W'(i_sample.raw_sample[31:0]);
            ENC_FLOAT32: begin
                n_dec.flt = 1'b1;
                n_dec.neg = i_sample.raw_sample[31];
                e_raw     = (EXP_W-2)'(i_sample.raw_sample[30:23]);
                m_raw     = {i_sample.raw_sample[22:0], 29'd0};
                e_ones    = &i_sample.raw_sample[30:23];
            end
            ENC_FLOAT64: begin
                n_dec.flt = 1'b1;
                n_dec.neg = i_sample.raw_sample[63];
                e_raw     = i_sample.raw_sample[62:52];
                m_raw     = i_sample.raw_sample[51:0];
                e_ones    = &i_sample.raw_sample[62:52];
            end
            default:     n_dec.bad = 1'b1;
        endcase
        n_dec.vint  = (xs << FRAC_BITS) ^ BIAS;
        n_dec.nan   = e_ones && (m_raw != '0);
        n_dec.inf   = e_ones && (m_raw == '0);
        n_dec.zero  = (e_raw == '0) && (m_raw == '0);
        e_eff       = (e_raw == '0) ? (EXP_W-2)'(1) : e_raw;
        n_dec.mant  = {(e_raw != '0), m_raw};
        if (r_enc == ENC_FLOAT32) begin
            // Float32 mantissa sits left aligned; undo the alignment.
            n_dec.mant  = MANT_W'({(e_raw != '0), m_raw[51:29]});
            n_dec.shamt = $signed({2'b00, e_eff}) - F32_OFS;
        end else begin
            n_dec.shamt = $signed({2'b00, e_eff}) - F64_OFS;
        end
    end

    // Stage 2: mantissa shift.
    always_comb begin
        n_shf.vld  = r_dec.vld;
        n_shf.last = r_dec.last;
        n_shf.bad  = r_dec.bad;
        n_shf.flt  = r_dec.flt;
        n_shf.vint = r_dec.vint;
        n_shf.neg  = r_dec.neg;
        n_shf.nan  = r_dec.nan;
        n_shf.inf  = r_dec.inf;
        n_shf.zero = r_dec.zero;
        wide       = {{VAL_W{1'b0}}, r_dec.mant} << r_dec.shamt[5:0];
        rsh        = -r_dec.shamt;
        if (!r_dec.shamt[EXP_W-1]) begin
            n_shf.big  = r_dec.shamt >= EXP_W'(signed'(VAL_W));
            n_shf.over = |wide[WIDE_W-1:VAL_W];
            n_shf.mag  = wide[VAL_W-1:0];
        end else begin
            n_shf.big  = 1'b0;
            n_shf.over = 1'b0;
            n_shf.mag  = (rsh >= EXP_W'(64)) ? '0 : VAL_W'(r_dec.mant >> rsh[5:0]);
        end
    end

    // Stage 3: saturation and offset-binary fixed point.
    always_comb begin
        n_fix.vld  = r_shf.vld;
        n_fix.last = r_shf.last;
        n_fix.bad  = r_shf.bad;
        limit      = r_shf.neg ? BIAS : BIAS - VAL_W'(1);
        priority if (r_shf.inf) begin
            mag = limit;
        end else if (r_shf.zero) begin
            mag = '0;
        end else if (r_shf.big || r_shf.over || (r_shf.mag > limit)) begin
            mag = limit;
        end else begin
            mag = r_shf.mag;
        end
        priority if (!r_shf.flt) begin
            n_fix.val = r_shf.vint;
        end else if (r_shf.nan) begin
            n_fix.val = BIAS;
        end else begin
            n_fix.val = r_shf.neg ? BIAS - mag : BIAS + mag;
        end
    end

    // Stage 4: bound compare.
    always_comb begin
        n_cmp.vld  = r_fix.vld;
        n_cmp.last = r_fix.last;
        n_cmp.bad  = r_fix.bad;
        n_cmp.le   = r_fix.val <= lo_b;
        n_cmp.ge   = r_fix.val >= hi_b;
        n_cmp.diff = r_fix.val - lo_b;
        n_cmp.den  = hi_b - lo_b;
    end

    // Stage 5 forms diff * 255; the following stages divide one bit at a time.
    always_comb begin
        n_div[0].vld  = r_cmp.vld;
        n_div[0].last = r_cmp.last;
        n_div[0].bad  = r_cmp.bad;
        n_div[0].le   = r_cmp.le;
        n_div[0].ge   = r_cmp.ge;
        n_div[0].rem  = {r_cmp.diff, 8'd0} - NUM_W'(r_cmp.diff);
        n_div[0].den  = r_cmp.den;
        n_div[0].quo  = '0;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [NUM_W-1:0] sub;
        assign sub = NUM_W'(r_div[k-1].den) << (DIV_STEPS - k);
        always_comb begin
            n_div[k] = r_div[k-1];
            if (r_div[k-1].rem >= sub) begin
                n_div[k].rem              = r_div[k-1].rem - sub;
                n_div[k].quo[DIV_STEPS-k] = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (r_div[DIV_STEPS].bad) begin
            n_out_gray = GRAY_MAX;
        end else if (r_div[DIV_STEPS].le) begin
            n_out_gray = '0;
        end else if (r_div[DIV_STEPS].ge) begin
            n_out_gray = GRAY_MAX;
        end else begin
            n_out_gray = r_div[DIV_STEPS].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec      <= '0;
            r_shf      <= '0;
            r_fix      <= '0;
            r_cmp      <= '0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
            r_out_gray <= '0;
        end else if (en) begin
            r_dec      <= n_dec;
            r_shf      <= n_shf;
            r_fix      <= n_fix;
            r_cmp      <= n_cmp;
            r_out_vld  <= r_div[DIV_STEPS].vld;
            r_out_last <= r_div[DIV_STEPS].last;
            r_out_gray <= n_out_gray;
        end
    end

    for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_divreg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k] <= '0;
            end else if (en) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    assign o_gray.valid      = r_out_vld;
    assign o_gray.gray_level = r_out_gray;
    assign o_gray.last_pixel = r_out_last;

    `GS2G_ASSERT(a_ready_only_on_stall, i_clk, i_rst_n, i_sample.ready || (o_gray.valid && !o_gray.ready), "sample ready dropped without an output stall")
    `GS2G_ASSERT_NEXT(a_first_stage_moves, i_clk, i_rst_n, en && r_dec.vld, r_shf.vld, "decoded request lost between stages")
    `GS2G_ASSERT_NEXT(a_stall_holds_last_div, i_clk, i_rst_n, !en, $stable(r_div[DIV_STEPS].quo) && $stable(r_cmp.vld), "pipeline changed during a stall")
    `GS2G_ASSERT_NEXT(a_div_reaches_out, i_clk, i_rst_n, en && r_div[DIV_STEPS].vld, r_out_vld, "divider result not registered at the output")
endmodule
`default_nettype wire
